>>> hw/rtl/bbf_pkg.sv
package bbf_pkg;

  localparam int unsigned HashCountW = 6;
  localparam logic [HashCountW-1:0] HashCountReset = 6'd7;

  localparam int unsigned KeyW = 64;
  localparam int unsigned BitSelW = 6;

  localparam logic [KeyW-1:0] SmGamma = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [KeyW-1:0] SmMul1 = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [KeyW-1:0] SmMul2 = 64'h94D0_49BB_1331_11EB;

  localparam int unsigned SmShiftA = 30;
  localparam int unsigned SmShiftB = 27;
  localparam int unsigned SmShiftC = 31;

  localparam logic ReqInsert = 1'b0;
  localparam logic ReqQuery = 1'b1;

  typedef enum logic [3:0] {
    MX_IDLE,
    MX_ADD,
    MX_M1_LL,
    MX_M1_HL,
    MX_M1_LH,
    MX_M2_LL,
    MX_M2_HL,
    MX_M2_LH,
    MX_DONE
  } mix_state_e;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_HASH
  } back_state_e;

endpackage

>>> hw/rtl/bbf_ram.sv
module bbf_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hw/rtl/bbf_mix.sv
module bbf_mix (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [bbf_pkg::KeyW-1:0]        seed_i,
  input  logic [bbf_pkg::HashCountW-1:0]  hash_count_i,
  output logic                            done_o,
  output logic [bbf_pkg::KeyW-1:0]        picked_o
);

  import bbf_pkg::*;

  localparam int unsigned HalfW = KeyW / 2;

  mix_state_e state_q, state_d;

  logic [KeyW-1:0]       st_q, st_d;
  logic [KeyW-1:0]       x_q, x_d;
  logic [KeyW-1:0]       acc_q, acc_d;
  logic [KeyW-1:0]       picked_q, picked_d;
  logic [HashCountW-1:0] round_q, round_d;
  logic                  first_q, first_d;

  logic [HalfW-1:0] mul_a;
  logic [HalfW-1:0] mul_b;
  logic [KeyW-1:0]  prod;
  logic [KeyW-1:0]  mix_y;
  logic [KeyW-1:0]  mix_z;
  logic [KeyW-1:0]  st_add;

  assign mix_y  = acc_q ^ (acc_q >> SmShiftB);
  assign mix_z  = acc_q ^ (acc_q >> SmShiftC);
  assign st_add = st_q + SmGamma;

  // one 32x32 multiplier, three partial products per 64-bit multiply
  always_comb begin
    mul_a = x_q[HalfW-1:0];
    mul_b = SmMul1[HalfW-1:0];
    case (state_q)
      MX_M1_HL: mul_a = x_q[KeyW-1:HalfW];
      MX_M1_LH: mul_b = SmMul1[KeyW-1:HalfW];
      MX_M2_LL: begin
        mul_a = mix_y[HalfW-1:0];
        mul_b = SmMul2[HalfW-1:0];
      end
      MX_M2_HL: begin
        mul_a = x_q[KeyW-1:HalfW];
        mul_b = SmMul2[HalfW-1:0];
      end
      MX_M2_LH: mul_b = SmMul2[KeyW-1:HalfW];
      default: ;
    endcase
  end

  assign prod = KeyW'(mul_a) * KeyW'(mul_b);

  always_comb begin
    state_d = state_q;
    case (state_q)
      MX_IDLE, MX_DONE: begin
        if (start_i) state_d = MX_ADD;
      end
      MX_ADD: begin
        if (round_q == hash_count_i) state_d = MX_DONE;
        else state_d = MX_M1_LL;
      end
      MX_M1_LL: state_d = MX_M1_HL;
      MX_M1_HL: state_d = MX_M1_LH;
      MX_M1_LH: state_d = MX_M2_LL;
      MX_M2_LL: state_d = MX_M2_HL;
      MX_M2_HL: state_d = MX_M2_LH;
      MX_M2_LH: state_d = MX_ADD;
      default:  state_d = MX_IDLE;
    endcase
  end

  always_comb begin
    st_d     = st_q;
    x_d      = x_q;
    acc_d    = acc_q;
    picked_d = picked_q;
    round_d  = round_q;
    first_d  = first_q;
    case (state_q)
      MX_IDLE, MX_DONE: begin
        if (start_i) begin
          st_d     = seed_i;
          picked_d = '0;
          round_d  = '0;
          first_d  = 1'b1;
        end
      end
      MX_ADD: begin
        if (!first_q) begin
          picked_d = picked_q | (KeyW'(1) << mix_z[BitSelW-1:0]);
        end
        first_d = 1'b0;
        st_d    = st_add;
        x_d     = st_add ^ (st_add >> SmShiftA);
      end
      MX_M1_LL: acc_d = prod;
      MX_M1_HL, MX_M1_LH, MX_M2_HL: begin
        acc_d[KeyW-1:HalfW] = acc_q[KeyW-1:HalfW] + prod[HalfW-1:0];
      end
      MX_M2_LL: begin
        x_d   = mix_y;
        acc_d = prod;
      end
      MX_M2_LH: begin
        acc_d[KeyW-1:HalfW] = acc_q[KeyW-1:HalfW] + prod[HalfW-1:0];
        round_d = round_q + HashCountW'(1);
      end
      default: ;
    endcase
  end

  always_comb begin
    done_o   = (state_q == MX_DONE);
    picked_o = picked_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= MX_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    st_q     <= st_d;
    x_q      <= x_d;
    acc_q    <= acc_d;
    picked_q <= picked_d;
    round_q  <= round_d;
    first_q  <= first_d;
  end

endmodule

>>> hw/rtl/bbf_front.sv
module bbf_front #(
  parameter int unsigned NumWords = 1024,
  localparam int unsigned IdxW = (NumWords > 1) ? $clog2(NumWords) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic                     req_type_i,
  input  logic [bbf_pkg::KeyW-1:0] digest_i,
  input  logic                     clearing_i,
  output logic                     q_valid_o,
  output logic                     q_req_type_o,
  output logic [IdxW-1:0]          q_idx_o,
  output logic [bbf_pkg::KeyW-1:0] q_digest_o,
  input  logic                     q_pop_i
);

  import bbf_pkg::*;

  localparam int unsigned QDepth = 2;
  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  logic            req_q [QDepth];
  logic [IdxW-1:0] idx_q [QDepth];
  logic [KeyW-1:0] dig_q [QDepth];

  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  logic            push;
  logic            pop;
  logic            full;
  logic [IdxW-1:0] raw_idx;
  logic [IdxW-1:0] word_idx;

  // top bits of the digest, folded once into the store's range
  always_comb begin
    raw_idx = (NumWords > 1) ? digest_i[KeyW-1 -: IdxW] : '0;
    if ({1'b0, raw_idx} >= (IdxW + 1)'(NumWords)) begin
      word_idx = raw_idx - IdxW'(NumWords);
    end else begin
      word_idx = raw_idx;
    end
  end

  assign full       = (cnt_q == CntW'(QDepth));
  assign in_ready_o = !full && !clearing_i;
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    case ({push, pop})
      2'b10:   cnt_d = cnt_q + CntW'(1);
      2'b01:   cnt_d = cnt_q - CntW'(1);
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      req_q[wr_ptr_q] <= req_type_i;
      idx_q[wr_ptr_q] <= word_idx;
      dig_q[wr_ptr_q] <= digest_i;
    end
  end

  assign q_valid_o    = (cnt_q != '0);
  assign q_req_type_o = req_q[rd_ptr_q];
  assign q_idx_o      = idx_q[rd_ptr_q];
  assign q_digest_o   = dig_q[rd_ptr_q];

endmodule

>>> hw/rtl/bbf_back.sv
module bbf_back #(
  parameter int unsigned NumWords = 1024,
  localparam int unsigned IdxW = (NumWords > 1) ? $clog2(NumWords) : 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic [bbf_pkg::HashCountW-1:0] hash_count_i,
  input  logic                           q_valid_i,
  input  logic                           q_req_type_i,
  input  logic [IdxW-1:0]                q_idx_i,
  input  logic [bbf_pkg::KeyW-1:0]       q_digest_i,
  output logic                           q_pop_o,
  output logic                           clearing_o,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           maybe_present_o
);

  import bbf_pkg::*;

  back_state_e state_q, state_d;

  logic [IdxW-1:0] clr_addr_q, clr_addr_d;
  logic            cur_req_q;
  logic [IdxW-1:0] cur_idx_q;
  logic            out_valid_q;
  logic            maybe_q;

  logic            ram_we;
  logic [IdxW-1:0] ram_waddr;
  logic [KeyW-1:0] ram_wdata;
  logic            ram_re;
  logic [KeyW-1:0] ram_rdata;

  logic            mix_start;
  logic            mix_done;
  logic [KeyW-1:0] picked;

  logic finish;
  logic clr_last;
  logic hit;

  bbf_mix u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (mix_start),
    .seed_i       (q_digest_i),
    .hash_count_i (hash_count_i),
    .done_o       (mix_done),
    .picked_o     (picked)
  );

  bbf_ram #(
    .Width (KeyW),
    .Depth (NumWords)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (q_idx_i),
    .rdata_o (ram_rdata)
  );

  assign finish   = mix_done && (!out_valid_q || out_ready_i);
  assign clr_last = (clr_addr_q == IdxW'(NumWords - 1));
  assign hit      = ((ram_rdata & picked) == picked);

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_CLEAR: if (clr_last) state_d = BK_IDLE;
      BK_IDLE:  if (q_valid_i) state_d = BK_HASH;
      BK_HASH:  if (finish) state_d = BK_IDLE;
      default:  state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    ram_we     = 1'b0;
    ram_waddr  = cur_idx_q;
    ram_wdata  = ram_rdata | picked;
    ram_re     = 1'b0;
    q_pop_o    = 1'b0;
    mix_start  = 1'b0;
    clearing_o = 1'b0;
    clr_addr_d = clr_addr_q;
    case (state_q)
      BK_CLEAR: begin
        clearing_o = 1'b1;
        ram_we     = 1'b1;
        ram_waddr  = clr_addr_q;
        ram_wdata  = '0;
        clr_addr_d = clr_addr_q + IdxW'(1);
      end
      BK_IDLE: begin
        if (q_valid_i) begin
          q_pop_o   = 1'b1;
          ram_re    = 1'b1;
          mix_start = 1'b1;
        end
      end
      BK_HASH: begin
        if (finish) begin
          ram_we = (cur_req_q == ReqInsert);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_addr_q <= clr_addr_d;
      if (state_q == BK_HASH && finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      cur_req_q <= q_req_type_i;
      cur_idx_q <= q_idx_i;
    end
    if (state_q == BK_HASH && finish) begin
      maybe_q <= (cur_req_q == ReqQuery) ? hit : 1'b1;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign maybe_present_o = maybe_q;

endmodule

>>> hw/rtl/blocked_bloom_filter_unit.sv
// Blocked Bloom filter over NumWords words of 64 bits. Each transaction
// carries a key digest and an insert or query request; the top bits of the
// digest pick one word and hash_count SplitMix64 steps seeded with the digest
// pick bits within it. Inserts set those bits and answer 1; queries answer 1
// only when all of them are already set. Exactly one result comes back per
// request, in order. After reset the store is cleared one word a cycle, so
// no request is taken until every word is cleared; configuration writes
// are taken at any time but must only be made while the block is idle. Items
// are worked one at a time; the single 32x32 multiplier forms each 64-bit
// product of a SplitMix64 step in three partial products, and a two-entry
// queue in front lets up to two further requests be taken meanwhile.
module blocked_bloom_filter_unit #(
  parameter int unsigned NumWords = 1024
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bbf_pkg::HashCountW-1:0] cfg_hash_count_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           req_type_i,
  input  logic [bbf_pkg::KeyW-1:0]       digest_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           maybe_present_o
);

  import bbf_pkg::*;

  localparam int unsigned IdxW = (NumWords > 1) ? $clog2(NumWords) : 1;

  logic [HashCountW-1:0] hash_count_q;

  logic            q_valid;
  logic            q_req_type;
  logic [IdxW-1:0] q_idx;
  logic [KeyW-1:0] q_digest;
  logic            q_pop;
  logic            clearing;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_count_q <= HashCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      hash_count_q <= cfg_hash_count_i;
    end
  end

  bbf_front #(
    .NumWords (NumWords)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .req_type_i   (req_type_i),
    .digest_i     (digest_i),
    .clearing_i   (clearing),
    .q_valid_o    (q_valid),
    .q_req_type_o (q_req_type),
    .q_idx_o      (q_idx),
    .q_digest_o   (q_digest),
    .q_pop_i      (q_pop)
  );

  bbf_back #(
    .NumWords (NumWords)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .hash_count_i    (hash_count_q),
    .q_valid_i       (q_valid),
    .q_req_type_i    (q_req_type),
    .q_idx_i         (q_idx),
    .q_digest_i      (q_digest),
    .q_pop_o         (q_pop),
    .clearing_o      (clearing),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .maybe_present_o (maybe_present_o)
  );

endmodule
